@@ sv/thermostatic_fan_pwm_top_macros.svh @@
// assertion macros for the thermostatic fan controller
// each macro samples on clk and is disabled while arst_n is low
`ifndef THERMOSTATIC_FAN_PWM_TOP_MACROS_SVH
`define THERMOSTATIC_FAN_PWM_TOP_MACROS_SVH

// property that must hold at every edge
`define TFP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define TFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tfp_pkg.sv @@
`timescale 1ns / 1ps

package tfp_pkg;

	// pwm period in ticks, counter counts 0 .. PWM_PERIOD-1
	localparam int unsigned CNT_W      = 7;
	localparam logic [CNT_W-1:0] PWM_PERIOD = 7'd100;

	localparam int unsigned VAL_W = 7;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_FLOOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_CEIL  = 3'd4;

	// reset values
	localparam logic [VAL_W-1:0] RST_DUTY_LOW  = 7'd50;
	localparam logic [VAL_W-1:0] RST_DUTY_MID  = 7'd75;
	localparam logic [VAL_W-1:0] RST_DUTY_HIGH = 7'd100;
	localparam logic [VAL_W-1:0] RST_THR_FLOOR = 7'd12;
	localparam logic [VAL_W-1:0] RST_THR_CEIL  = 7'd125;
	localparam logic [VAL_W-1:0] RST_THRESHOLD = 7'd20;

	// request kinds and key codes
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_CTRL = 1'b1;

	localparam logic [1:0] KEY_NONE  = 2'd0;
	localparam logic [1:0] KEY_RAISE = 2'd1;
	localparam logic [1:0] KEY_LOWER = 2'd2;
	localparam logic [1:0] KEY_SPEED = 2'd3;

	// speed settings
	localparam logic [1:0] SPEED_LOW  = 2'd1;
	localparam logic [1:0] SPEED_MID  = 2'd2;
	localparam logic [1:0] SPEED_HIGH = 2'd3;

	typedef struct packed {
		logic              req_type;
		logic [1:0]        key_code;
		logic signed [11:0] temperature;
	} req_t;

	typedef struct packed {
		logic             motor_on;
		logic             over_temp;
		logic [VAL_W-1:0] threshold_now;
		logic [1:0]       speed_now;
		logic [VAL_W-1:0] duty_now;
	} rsp_t;

endpackage

@@ sv/thermostatic_fan_pwm_top.sv @@
`timescale 1ns / 1ps
// thermostatic fan controller with pwm drive
// request channel: req_valid / req_stall carry one req_t transaction, either a
//   pwm tick (req_type 0) or a control pass with key code and temperature in
//   signed 1/16 degree units (req_type 1)
// response channel: rsp_valid / rsp_stall carry one rsp_t transaction per
//   request, showing the state after that request has been applied
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, writes to unused indexes are dropped; write only when idle
// path: an accepted request is held in the input register and its response is
//   written when advance is high (one input register, one response register)
// throughput: one transaction per clock when rsp_stall is low; the state
//   update is one pass of small compares and increments between the registers
// stall: while rsp_stall holds a pending response, one more request can still
//   be taken into the input register; req_stall rises only when both are full
// reset: asynchronous, arst_n low; threshold 20, speed 1, counter, duty, over
//   flag and motor level 0, config registers back to their defaults
`include "thermostatic_fan_pwm_top_macros.svh"

module thermostatic_fan_pwm_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  tfp_pkg::req_t                req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output tfp_pkg::rsp_t                rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tfp_pkg::VAL_W-1:0]    cfg_data
);

	// configuration registers
	logic [tfp_pkg::VAL_W-1:0] duty_low_q, duty_mid_q, duty_high_q;
	logic [tfp_pkg::VAL_W-1:0] thr_floor_q, thr_ceil_q;

	// controller state
	logic [tfp_pkg::CNT_W-1:0] count_q;
	logic [tfp_pkg::VAL_W-1:0] duty_q;
	logic [tfp_pkg::VAL_W-1:0] thr_q;
	logic [1:0]                speed_q;
	logic                      over_q;
	logic                      motor_q;

	// input stage and response register
	logic          valid_s1;
	tfp_pkg::req_t req_s1;
	logic          rsp_valid_q;
	tfp_pkg::rsp_t rsp_q;

	logic advance;
	logic req_take;

	// next-state values for the item in the input stage
	logic [tfp_pkg::CNT_W-1:0] count_nxt;
	logic [tfp_pkg::VAL_W-1:0] duty_nxt;
	logic [tfp_pkg::VAL_W-1:0] thr_nxt;
	logic [1:0]                speed_nxt;
	logic                      over_nxt;
	logic                      motor_nxt;
	logic [tfp_pkg::VAL_W:0]   thr_up;
	logic [tfp_pkg::VAL_W-1:0] thr_key;
	logic [tfp_pkg::VAL_W-1:0] speed_duty;
	logic signed [12:0]        temp_ext;
	logic signed [12:0]        thr_scaled;

	// the response register moves when it is empty or being taken
	assign advance   = !rsp_valid_q || !rsp_stall;
	// input stage is free when empty or draining into the response register
	assign req_stall = valid_s1 && !advance;
	assign req_take  = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		// threshold after the key, raise saturates at the ceiling
		thr_up  = {1'b0, thr_q} + 8'd1;
		thr_key = thr_q;
		case (req_s1.key_code)
			tfp_pkg::KEY_RAISE: begin
				if (thr_up > {1'b0, thr_ceil_q}) begin
					thr_key = thr_ceil_q;
				end else begin
					thr_key = thr_up[tfp_pkg::VAL_W-1:0];
				end
			end
			tfp_pkg::KEY_LOWER: begin
				// zero would go negative, so it always lands on the floor
				if (thr_q == '0 || (thr_q - 7'd1) < thr_floor_q) begin
					thr_key = thr_floor_q;
				end else begin
					thr_key = thr_q - 7'd1;
				end
			end
			default: begin
				thr_key = thr_q;
			end
		endcase

		if (req_s1.key_code == tfp_pkg::KEY_SPEED) begin
			speed_nxt = (speed_q == tfp_pkg::SPEED_HIGH) ? tfp_pkg::SPEED_LOW : speed_q + 2'd1;
		end else begin
			speed_nxt = speed_q;
		end

		case (speed_nxt)
			tfp_pkg::SPEED_LOW:  speed_duty = duty_low_q;
			tfp_pkg::SPEED_MID:  speed_duty = duty_mid_q;
			tfp_pkg::SPEED_HIGH: speed_duty = duty_high_q;
			default:             speed_duty = '0;
		endcase

		// compare in 1/16 degree units, threshold * 16 fits in 13 bits signed
		temp_ext   = {req_s1.temperature[11], req_s1.temperature};
		thr_scaled = $signed({2'b00, thr_key, 4'b0000});

		// pwm counter wraps at the period
		if (count_q + 7'd1 == tfp_pkg::PWM_PERIOD) begin
			count_nxt = '0;
		end else begin
			count_nxt = count_q + 7'd1;
		end

		if (req_s1.req_type == tfp_pkg::REQ_TICK) begin
			thr_nxt   = thr_q;
			speed_nxt = speed_q;
			over_nxt  = over_q;
			duty_nxt  = duty_q;
			motor_nxt = count_nxt < duty_q;
		end else begin
			count_nxt = count_q;
			thr_nxt   = thr_key;
			over_nxt  = temp_ext > thr_scaled;
			duty_nxt  = over_nxt ? speed_duty : '0;
			// motor level only follows the new duty from the next tick
			motor_nxt = motor_q;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req;
		end
	end

	// state update and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			duty_q      <= '0;
			thr_q       <= tfp_pkg::RST_THRESHOLD;
			speed_q     <= tfp_pkg::SPEED_LOW;
			over_q      <= 1'b0;
			motor_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				count_q <= count_nxt;
				duty_q  <= duty_nxt;
				thr_q   <= thr_nxt;
				speed_q <= speed_nxt;
				over_q  <= over_nxt;
				motor_q <= motor_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q.motor_on      <= motor_nxt;
			rsp_q.over_temp     <= over_nxt;
			rsp_q.threshold_now <= thr_nxt;
			rsp_q.speed_now     <= speed_nxt;
			rsp_q.duty_now      <= duty_nxt;
		end
	end

	// configuration writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_low_q  <= tfp_pkg::RST_DUTY_LOW;
			duty_mid_q  <= tfp_pkg::RST_DUTY_MID;
			duty_high_q <= tfp_pkg::RST_DUTY_HIGH;
			thr_floor_q <= tfp_pkg::RST_THR_FLOOR;
			thr_ceil_q  <= tfp_pkg::RST_THR_CEIL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tfp_pkg::CFG_DUTY_LOW:  duty_low_q  <= cfg_data;
				tfp_pkg::CFG_DUTY_MID:  duty_mid_q  <= cfg_data;
				tfp_pkg::CFG_DUTY_HIGH: duty_high_q <= cfg_data;
				tfp_pkg::CFG_THR_FLOOR: thr_floor_q <= cfg_data;
				tfp_pkg::CFG_THR_CEIL:  thr_ceil_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// checks on the controller state and the pipeline hand-off
	`TFP_ASSERT_ALWAYS(a_count_in_period, count_q < tfp_pkg::PWM_PERIOD, "pwm counter left its period")
	`TFP_ASSERT_ALWAYS(a_speed_nonzero, speed_q != 2'd0, "speed setting reached zero")
	`TFP_ASSERT_NEXT(a_stage_drains, valid_s1 && advance, rsp_valid_q, "input stage item lost")

endmodule

@@ tb/sv/tb_thermostatic_fan_pwm_top.sv @@
`timescale 1ns / 1ps

module tb_thermostatic_fan_pwm_top;
	import tfp_pkg::*;

	// generous bound for ~1350 transactions, with room for stalls and idle gaps
	localparam int CYCLE_LIMIT = 200000;
	// random transactions per configuration phase
	localparam int PHASE_ITEMS = 265;
	localparam int NUM_PHASES  = 5;
	// settle cycles after the last response (two-stage pipeline plus margin)
	localparam int SETTLE      = 4;

	// expected-response store with its own copy of the controller state
	class fan_scoreboard;
		// register copies
		logic [VAL_W-1:0] duty_lo, duty_md, duty_hi, thr_floor, thr_ceil;
		// controller state
		logic [CNT_W-1:0] pwm_cnt;
		logic [VAL_W-1:0] duty_cmp, thr;
		logic [1:0]       speed;
		logic             over, motor;
		rsp_t             pending[$];
		int               errors, ticks, passes, checked;

		function new();
			duty_lo   = RST_DUTY_LOW;
			duty_md   = RST_DUTY_MID;
			duty_hi   = RST_DUTY_HIGH;
			thr_floor = RST_THR_FLOOR;
			thr_ceil  = RST_THR_CEIL;
			pwm_cnt   = '0;
			duty_cmp  = '0;
			thr       = RST_THRESHOLD;
			speed     = SPEED_LOW;
			over      = 1'b0;
			motor     = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
			case (idx)
				CFG_DUTY_LOW:  duty_lo   = val;
				CFG_DUTY_MID:  duty_md   = val;
				CFG_DUTY_HIGH: duty_hi   = val;
				CFG_THR_FLOOR: thr_floor = val;
				CFG_THR_CEIL:  thr_ceil  = val;
				default: ;
			endcase
		endfunction

		function logic [VAL_W-1:0] speed_duty();
			case (speed)
				SPEED_LOW:  return duty_lo;
				SPEED_MID:  return duty_md;
				SPEED_HIGH: return duty_hi;
				default:    return '0;
			endcase
		endfunction

		// advance the state by one accepted request and queue the response it implies
		function void note_request(req_t r);
			int   t;
			rsp_t e;
			if (r.req_type == REQ_TICK) begin
				ticks++;
				pwm_cnt = CNT_W'((int'(pwm_cnt) + 1) % int'(PWM_PERIOD));
				motor   = (pwm_cnt < duty_cmp);
			end else begin
				passes++;
				case (r.key_code)
					KEY_RAISE: begin
						t = int'(thr) + 1;
						if (t > int'(thr_ceil))
							t = int'(thr_ceil);
						thr = VAL_W'(t);
					end
					KEY_LOWER: begin
						t = int'(thr) - 1;
						if (t < int'(thr_floor))
							t = int'(thr_floor);
						thr = VAL_W'(t);
					end
					KEY_SPEED: speed = (speed == SPEED_HIGH) ? SPEED_LOW : speed + 2'd1;
					default: ;
				endcase
				if (int'($signed(r.temperature)) > int'(thr) * 16) begin
					over     = 1'b1;
					duty_cmp = speed_duty();
				end else begin
					over     = 1'b0;
					duty_cmp = '0;
				end
			end
			e.motor_on      = motor;
			e.over_temp     = over;
			e.threshold_now = thr;
			e.speed_now     = speed;
			e.duty_now      = duty_cmp;
			pending.push_back(e);
		endfunction

		function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
			if (got_v !== exp_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected response, expected none, actual %p", $time, got);
				return;
			end
			e = pending.pop_front();
			checked++;
			cmp_field("motor_on", 8'(e.motor_on), 8'(got.motor_on));
			cmp_field("over_temp", 8'(e.over_temp), 8'(got.over_temp));
			cmp_field("threshold_now", 8'(e.threshold_now), 8'(got.threshold_now));
			cmp_field("speed_now", 8'(e.speed_now), 8'(got.speed_now));
			cmp_field("duty_now", 8'(e.duty_now), 8'(got.duty_now));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid, req_stall;
	req_t                 req;
	logic                 rsp_valid, rsp_stall;
	rsp_t                 rsp;
	logic                 cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;

	fan_scoreboard sb = new();
	bit            no_idle = 1'b0;
	int            cfg_writes = 0;
	int            settings = 0;
	int            cycle_count;

	thermostatic_fan_pwm_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// monitor: sample both handshakes at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
	end

	// receiver back-pressure: stall about a quarter of the cycles, none in the quiet phase
	always @(negedge clk) begin
		rsp_stall <= !no_idle && ($urandom_range(99) < 24);
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// a control pass with a chosen key and temperature in 1/16 degree units
	function automatic req_t ctrl_req(logic [1:0] key, int temp);
		req_t r;
		r.req_type    = REQ_CTRL;
		r.key_code    = key;
		r.temperature = 12'(temp);
		return r;
	endfunction

	// a tick carries junk in the key and temperature fields, which must be ignored
	function automatic req_t tick_req();
		req_t r;
		r.req_type    = REQ_TICK;
		r.key_code    = 2'($urandom_range(3));
		r.temperature = 12'($urandom());
		return r;
	endfunction

	// mostly ticks so the counter sweeps its period; control temperatures often
	// straddle the current threshold to hit the strictly-above boundary
	function automatic req_t random_req();
		int temp;
		if ($urandom_range(99) < 65)
			return tick_req();
		if ($urandom_range(1))
			temp = int'(sb.thr) * 16 + int'($urandom_range(4)) - 2;
		else
			temp = int'($urandom()) % 4096 - 2048;
		return ctrl_req(2'($urandom_range(3)), temp);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance, valid left high
	task automatic put_req(input req_t r);
		int gap;
		if (!no_idle && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic stop_req();
		req_valid <= 1'b0;
	endtask

	// wait until every queued response has been checked, then let the pipe settle
	task automatic drain_responses();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	// one config transaction; valid is left high for back-to-back writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_writes++;
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [VAL_W-1:0] dl, input logic [VAL_W-1:0] dm,
		input logic [VAL_W-1:0] dh, input logic [VAL_W-1:0] fl, input logic [VAL_W-1:0] ce);
		write_reg(CFG_DUTY_LOW, dl);
		write_reg(CFG_DUTY_MID, dm);
		write_reg(CFG_DUTY_HIGH, dh);
		write_reg(CFG_THR_FLOOR, fl);
		write_reg(CFG_THR_CEIL, ce);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset settings: threshold 20 (320 in 1/16 degree), speed 1
		put_req(ctrl_req(KEY_NONE, 0));
		put_req(tick_req());
		put_req(ctrl_req(KEY_NONE, 2047));      // hottest reading, over
		put_req(tick_req());                    // motor follows the new duty only now
		put_req(ctrl_req(KEY_SPEED, 320));      // equal to threshold is not over
		put_req(ctrl_req(KEY_SPEED, 321));      // one lsb above, speed 3
		put_req(tick_req());
		put_req(ctrl_req(KEY_SPEED, -2048));    // coldest reading, speed wraps to 1
		put_req(ctrl_req(KEY_RAISE, 337));
		put_req(ctrl_req(KEY_LOWER, 320));
		put_req(ctrl_req(KEY_LOWER, 305));
		stop_req();
		drain_responses();

		// unused register indexes are dropped; then duty above the period,
		// a zero duty, and a floor above the ceiling with threshold between them
		for (int i = int'(CFG_THR_CEIL) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), '1);
		program_regs(7'd127, 7'd0, 7'd101, 7'd30, 7'd10);
		@(negedge clk);
		put_req(ctrl_req(KEY_NONE, 2047));
		put_req(tick_req());
		put_req(tick_req());
		put_req(tick_req());
		put_req(ctrl_req(KEY_RAISE, 0));        // raise lands on the ceiling, below start
		put_req(ctrl_req(KEY_LOWER, 0));        // lower lands on the floor, above start
		put_req(ctrl_req(KEY_SPEED, 2047));     // over with a zero duty
		put_req(tick_req());
		put_req(ctrl_req(KEY_SPEED, 2047));
		put_req(tick_req());
		stop_req();

		// random phases, each under its own register setting
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_responses();
			case (ph)
				1: program_regs('0, '0, '0, '0, '0);
				2: program_regs('1, '1, '1, '1, '1);
				3: program_regs(7'd100, 7'd99, 7'd1, 7'd0, 7'd127);
				default: program_regs(VAL_W'($urandom_range(127)), VAL_W'($urandom_range(127)),
					VAL_W'($urandom_range(127)), VAL_W'($urandom_range(127)),
					VAL_W'($urandom_range(127)));
			endcase
			@(negedge clk);
			// one long stretch with no idling on either side
			no_idle = (ph == 3);
			repeat (PHASE_ITEMS) put_req(random_req());
			stop_req();
		end
		no_idle = 1'b0;

		drain_responses();
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d pwm ticks and %0d control passes under %0d register settings",
			sb.ticks, sb.passes, settings + 1);
		$display("%0d responses compared, %0d config writes, %0d errors",
			sb.checked, cfg_writes, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
